@@ rtl/ang_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ang_pkg;

  // gain is unsigned q1.16, unity at 2^16
  localparam int unsigned GainWidth = 17;
  localparam logic [GainWidth-1:0] GainUnity = 17'h10000;
  localparam logic [7:0] SampleMid = 8'd128;

  // configuration register indexes
  typedef enum logic [1:0] {
    CfgGateLevel   = 2'd0,
    CfgHoldSamples = 2'd1,
    CfgReleaseStep = 2'd2,
    CfgAttackStep  = 2'd3
  } ang_cfg_idx_e;

  // gate state that the gain stage reads and rewrites
  typedef struct packed {
    logic                 gate_closed;
    logic                 releasing;
    logic [GainWidth-1:0] gain;
  } ang_gate_t;

  localparam ang_gate_t GateReset = '{gate_closed: 1'b0, releasing: 1'b0, gain: GainUnity};

endpackage

`default_nettype wire

@@ rtl/ang_gain_step.sv @@
`timescale 1ns / 1ps
`default_nettype none

// gain update and scaling for a sample seen while the gate is closed
module ang_gain_step
  import ang_pkg::*;
(
  input  wire logic [7:0]           sample_i,
  input  wire logic                 in_band_i,
  input  wire ang_gate_t            gate_i,
  input  wire logic [GainWidth-1:0] release_step_i,
  input  wire logic [GainWidth-1:0] attack_step_i,
  output ang_gate_t                 gate_o,
  output logic [7:0]                result_o
);

  logic [GainWidth:0]   attack_sum;
  logic [GainWidth-1:0] release_diff;
  logic [GainWidth-1:0] scale_gain;
  logic signed [8:0]    sample_off;
  logic signed [26:0]   product;
  logic signed [26:0]   acc;
  logic [7:0]           scaled;

  assign attack_sum   = {1'b0, gate_i.gain} + {1'b0, attack_step_i};
  assign release_diff = gate_i.gain - release_step_i;
  assign scale_gain   = in_band_i ? release_diff : attack_sum[GainWidth-1:0];

  // 128 + (s - 128) * g / 2^16, floored; the sum is never negative
  assign sample_off = $signed({1'b0, sample_i} - 9'd128);
  assign product    = $signed({{18{sample_off[8]}}, sample_off}) *
                      $signed({10'd0, scale_gain});
  assign acc        = product + 27'sd8388608;
  assign scaled     = acc[23:16];

  always_comb begin
    gate_o   = gate_i;
    result_o = sample_i;
    if (in_band_i) begin
      if (gate_i.releasing) begin
        if (release_step_i > gate_i.gain) begin
          gate_o.gain      = '0;
          gate_o.releasing = 1'b0;
          result_o         = SampleMid;
        end else begin
          gate_o.gain = release_diff;
          result_o    = scaled;
        end
      end else begin
        result_o = SampleMid;
      end
    end else begin
      if (attack_sum > {1'b0, GainUnity}) begin
        gate_o.gain        = GainUnity;
        gate_o.gate_closed = 1'b0;
      end else begin
        gate_o.gain = attack_sum[GainWidth-1:0];
        result_o    = scaled;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/audio_noise_gate_u8.sv @@
`timescale 1ns / 1ps
`default_nettype none

// a sample beat is held in the input register, then in the result register
// throughput: one sample per cycle unless stalled, set by that single register pair
// the gain, hold counter and flags update as a sample moves into the result register
// reset: asynchronous active low, clears the gate state and loads register defaults
// (gate level 0 so the gate is bypassed, hold 0, release and attack steps at unity)
module audio_noise_gate_u8
  import ang_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 20,
  localparam int unsigned CfgWidth = (COUNT_WIDTH > GainWidth) ? COUNT_WIDTH : GainWidth
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration write channel
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [1:0]          cfg_index_i,
  input  wire logic [CfgWidth-1:0] cfg_data_i,
  // sample input channel
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [7:0]          sample_in_i,
  input  wire logic                block_start_i,
  // sample output channel
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [7:0]               sample_out_o
);

  localparam int unsigned QuietWidth = COUNT_WIDTH + 1;

  // configuration registers
  logic [7:0]             gate_level_q;
  logic [COUNT_WIDTH-1:0] hold_samples_q;
  logic [GainWidth-1:0]   release_step_q;
  logic [GainWidth-1:0]   attack_step_q;

  // input register stage
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_sample_q;
  logic       s1_start_q;

  // result register stage
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_sample_q;

  // gate state
  logic [QuietWidth-1:0] quiet_count_q, quiet_count_d;
  ang_gate_t             gate_q, gate_d;

  logic                  in_accept;
  logic                  s1_advance;
  logic                  s1_fire;
  logic [QuietWidth-1:0] count_eff;
  logic [QuietWidth-1:0] count_inc;
  ang_gate_t             gate_eff;
  ang_gate_t             step_gate;
  logic [7:0]            step_result;
  logic [7:0]            result;
  logic                  in_band;
  logic [8:0]            low_sum;
  logic [8:0]            high_sum;

  // ------------------------------------------------------------------
  // handshakes: the result register frees the input stage when empty or
  // when its beat is taken, so unless the output stalls a new sample enters every cycle
  // ------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;
  assign s1_advance  = !out_valid_q || out_ready_i;
  assign in_ready_o  = !s1_valid_q || s1_advance;
  assign in_accept   = in_valid_i && in_ready_o;
  assign s1_fire     = s1_valid_q && s1_advance;

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_sample_q;

  // ------------------------------------------------------------------
  // configuration writes
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_level_q   <= '0;
      hold_samples_q <= '0;
      release_step_q <= GainUnity;
      attack_step_q  <= GainUnity;
    end else if (cfg_valid_i) begin
      unique case (ang_cfg_idx_e'(cfg_index_i))
        CfgGateLevel:   gate_level_q   <= cfg_data_i[7:0];
        CfgHoldSamples: hold_samples_q <= cfg_data_i[COUNT_WIDTH-1:0];
        CfgReleaseStep: release_step_q <= cfg_data_i[GainWidth-1:0];
        CfgAttackStep:  attack_step_q  <= cfg_data_i[GainWidth-1:0];
      endcase
    end
  end

  // ------------------------------------------------------------------
  // input register
  // ------------------------------------------------------------------
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_advance) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_sample_q <= sample_in_i;
      s1_start_q  <= block_start_i;
    end
  end

  // ------------------------------------------------------------------
  // per-sample gate logic
  // ------------------------------------------------------------------

  // block start wipes the state before this sample is looked at
  assign count_eff = s1_start_q ? '0 : quiet_count_q;
  assign gate_eff  = s1_start_q ? GateReset : gate_q;

  // strictly inside 128 +/- level; a level above 128 pushes the low edge below zero
  assign low_sum  = {1'b0, s1_sample_q} + {1'b0, gate_level_q};
  assign high_sum = {1'b0, SampleMid} + {1'b0, gate_level_q};
  assign in_band  = (low_sum > {1'b0, SampleMid}) && ({1'b0, s1_sample_q} < high_sum);

  // saturating in-band run length
  assign count_inc = (&count_eff) ? count_eff : count_eff + 1'b1;

  ang_gain_step u_gain_step (
    .sample_i       (s1_sample_q),
    .in_band_i      (in_band),
    .gate_i         (gate_eff),
    .release_step_i (release_step_q),
    .attack_step_i  (attack_step_q),
    .gate_o         (step_gate),
    .result_o       (step_result)
  );

  always_comb begin
    quiet_count_d = count_eff;
    gate_d        = gate_eff;
    result        = s1_sample_q;
    if (gate_level_q == '0) begin
      // bypass: pass the sample and keep the state, cleared only by a block start
      result = s1_sample_q;
    end else if (!gate_eff.gate_closed) begin
      // open gate: count the quiet run, close once it exceeds the hold
      if (in_band) begin
        quiet_count_d = count_inc;
        if (count_inc > {1'b0, hold_samples_q}) begin
          gate_d.gate_closed = 1'b1;
          gate_d.releasing   = 1'b1;
        end
      end else begin
        quiet_count_d = '0;
      end
    end else begin
      // closed gate: release fade or attack; the counter holds, cleared by loud samples
      gate_d = step_gate;
      result = step_result;
      if (!in_band) begin
        quiet_count_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_count_q <= '0;
      gate_q        <= GateReset;
    end else if (s1_fire) begin
      quiet_count_q <= quiet_count_d;
      gate_q        <= gate_d;
    end
  end

  // ------------------------------------------------------------------
  // result register
  // ------------------------------------------------------------------
  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_sample_q <= result;
    end
  end

endmodule

`default_nettype wire
